// File: rtl/srl_pkg.sv
// Package for the stereo linear resampler: shared constants, register
// indexes and the lane control struct. No dependencies.
package srl_pkg;

  // The configuration data port is as wide as the widest register.
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CUR_W      = 32;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_STEP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION_FRAMES = 2'd2;

  // Result count guard per source frame.
  localparam int unsigned CNT_W = 5;
  localparam logic [CNT_W-1:0] MAX_RESULTS = 5'd16;

  // Pipeline enables shared by both channel lanes.
  typedef struct packed {
    logic load_prod;
    logic load_out;
  } lane_ctl_t;

endpackage

// File: rtl/srl_lane.sv
// One channel lane of the resampler: a registered multiply followed by a
// truncating add into the output register. Depends on srl_pkg.
module srl_lane
  import srl_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  lane_ctl_t                     ctl_i,
  input  logic [FRAC_BITS-1:0]          phase_i,
  input  logic signed [SAMPLE_BITS-1:0] prev_i,
  input  logic signed [SAMPLE_BITS-1:0] new_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o
);

  localparam int unsigned DW = SAMPLE_BITS + 1;
  localparam int unsigned PW = FRAC_BITS + SAMPLE_BITS + 2;
  localparam int unsigned QW = SAMPLE_BITS + 2;

  logic signed [DW-1:0]          diff;
  logic signed [PW-1:0]          prod_d;
  logic signed [PW-1:0]          prod_q;
  logic signed [SAMPLE_BITS-1:0] base_q;
  logic        [PW-1:0]          bias;
  logic        [PW-1:0]          adj;
  logic        [QW-1:0]          sum;
  logic signed [SAMPLE_BITS-1:0] sample_q;

  assign diff   = {new_i[SAMPLE_BITS-1], new_i} - {prev_i[SAMPLE_BITS-1], prev_i};
  assign prod_d = $signed({1'b0, phase_i}) * diff;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_prod) begin
      prod_q <= prod_d;
      base_q <= prev_i;
    end
  end

  // Adding all ones in the fraction of a negative product makes the shift
  // round toward zero instead of toward minus infinity.
  assign bias = {{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{prod_q[PW-1]}}};
  assign adj  = prod_q + bias;
  assign sum  = {{2{base_q[SAMPLE_BITS-1]}}, base_q} + adj[PW-1:FRAC_BITS];

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_out) begin
      sample_q <= sum[SAMPLE_BITS-1:0];
    end
  end

  assign sample_o = sample_q;

endmodule

// File: rtl/stereo_linear_resampler.sv
// Stereo linear resampler. An accepted frame's results pass through the
// product register in each lane, then the output register. Throughput: one
// result per cycle while the output takes them; a frame gives 0..16 results,
// one per phase step of the sequencer, and the next frame waits for them.
// Reset (rst_ni low, asynchronous) clears phase, cursor and previous frame
// and restores the registers to pitch 1.0, looping off and the largest duration.
module stereo_linear_resampler
  import srl_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] right_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o,
  output logic                          last_o
);

  // The phase carries four integer bits above the fraction, enough for the
  // largest pitch added to a phase just below one.
  localparam int unsigned PH_W = FRAC_BITS + 4;
  localparam logic [PH_W-1:0] PH_ONE = PH_W'(1) << FRAC_BITS;
  localparam logic [CFG_DATA_W-1:0] PITCH_MIN = CFG_DATA_W'(1) << (FRAC_BITS - 4);
  localparam logic [CFG_DATA_W-1:0] PITCH_MAX = CFG_DATA_W'(8) << FRAC_BITS;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  state_e                 state_q, state_d;
  logic [PH_W-1:0]        phase_q, phase_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [CUR_W-1:0]       cursor_q, cursor_d;
  logic signed [SAMPLE_BITS-1:0] prev_l_q, prev_l_d, prev_r_q, prev_r_d;
  logic signed [SAMPLE_BITS-1:0] new_l_q, new_r_q;
  logic [PH_W-1:0]        pitch_q;
  logic                   loop_q;
  logic [CUR_W-1:0]       dur_q;
  logic                   p_valid_q, p_valid_d, p_last_q, p_last_d;
  logic                   o_valid_q, o_valid_d, o_last_q, o_last_d;

  lane_ctl_t              lane_ctl;
  logic                   in_accept;
  logic                   more;
  logic                   issue;
  logic [PH_W-1:0]        phase_step;
  logic [PH_W-1:0]        phase_sub;
  logic [CUR_W-1:0]       cursor_inc;
  logic [CFG_DATA_W-1:0]  pitch_sat;

  // The block takes a new frame only between frames; the output register and
  // the product stage let that happen while earlier results still wait.
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // The output register loads whenever it is empty or being taken, and the
  // product stage moves up behind it.
  assign lane_ctl.load_out  = !o_valid_q || !out_stall_i;
  assign lane_ctl.load_prod = !p_valid_q || lane_ctl.load_out;

  // A result is due while the phase is below one and the guard count allows.
  assign more       = (phase_q < PH_ONE) && (cnt_q < MAX_RESULTS);
  assign issue      = (state_q == S_RUN) && more && lane_ctl.load_prod;
  assign phase_step = phase_q + pitch_q;
  assign phase_sub  = (phase_q >= PH_ONE) ? (phase_q - PH_ONE) : phase_q;
  assign cursor_inc = cursor_q + CUR_W'(1);

  // Pitch writes saturate into the range of one sixteenth to eight.
  always_comb begin
    pitch_sat = cfg_data_i;
    if (cfg_data_i < PITCH_MIN) begin
      pitch_sat = PITCH_MIN;
    end else if (cfg_data_i > PITCH_MAX) begin
      pitch_sat = PITCH_MAX;
    end
  end

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    cursor_d  = cursor_q;
    prev_l_d  = prev_l_q;
    prev_r_d  = prev_r_q;
    p_valid_d = p_valid_q;
    p_last_d  = p_last_q;
    o_valid_d = o_valid_q;
    o_last_d  = o_last_q;

    if (lane_ctl.load_out) begin
      o_valid_d = p_valid_q;
      o_last_d  = p_last_q;
    end
    if (lane_ctl.load_prod) begin
      p_valid_d = issue;
      p_last_d  = (phase_step >= PH_ONE) || (cnt_q == MAX_RESULTS - CNT_W'(1));
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cnt_d   = '0;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (more) begin
          if (issue) begin
            phase_d = phase_step;
            cnt_d   = cnt_q + CNT_W'(1);
          end
        end else begin
          // End of the source frame: step the phase and cursor, wrapping both to
          // zero at the loop end, and keep the new frame as the start of the next segment.
          phase_d  = phase_sub;
          cursor_d = cursor_inc;
          if (loop_q && (cursor_inc >= dur_q)) begin
            cursor_d = '0;
            phase_d  = '0;
          end
          prev_l_d = new_l_q;
          prev_r_d = new_r_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= '0;
      cnt_q     <= '0;
      cursor_q  <= '0;
      prev_l_q  <= '0;
      prev_r_q  <= '0;
      p_valid_q <= 1'b0;
      p_last_q  <= 1'b0;
      o_valid_q <= 1'b0;
      o_last_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      cursor_q  <= cursor_d;
      prev_l_q  <= prev_l_d;
      prev_r_q  <= prev_r_d;
      p_valid_q <= p_valid_d;
      p_last_q  <= p_last_d;
      o_valid_q <= o_valid_d;
      o_last_q  <= o_last_d;
    end
  end

  // Configuration registers; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q <= PH_ONE;
      loop_q  <= 1'b0;
      dur_q   <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PITCH_STEP:      pitch_q <= pitch_sat[PH_W-1:0];
        CFG_LOOP_ENABLE:     loop_q  <= cfg_data_i[0];
        CFG_DURATION_FRAMES: dur_q   <= cfg_data_i[CUR_W-1:0];
        default: ;
      endcase
    end
  end

  // The incoming frame is held for the whole frame's interpolation.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      new_l_q <= left_in_i;
      new_r_q <= right_in_i;
    end
  end

  // Both channels run in their own lane with the shared phase; the output
  // register in each lane loads together with the valid and last flags above.
  srl_lane #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_lane_left (
    .clk_i   (clk_i),
    .ctl_i   (lane_ctl),
    .phase_i (phase_q[FRAC_BITS-1:0]),
    .prev_i  (prev_l_q),
    .new_i   (new_l_q),
    .sample_o(left_out_o)
  );

  srl_lane #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_lane_right (
    .clk_i   (clk_i),
    .ctl_i   (lane_ctl),
    .phase_i (phase_q[FRAC_BITS-1:0]),
    .prev_i  (prev_r_q),
    .new_i   (new_r_q),
    .sample_o(right_out_o)
  );

  assign out_valid_o = o_valid_q;
  assign last_o      = o_last_q;

endmodule

// File: rtl/srl_checker.sv
// Port-level checks for the stereo linear resampler, bound to the top level.
// Depends on stereo_linear_resampler.
module srl_checker #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [SAMPLE_BITS-1:0] left_out_o,
  input logic signed [SAMPLE_BITS-1:0] right_out_o,
  input logic                          last_o
);

  // A frame that was just taken leaves the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block took a frame and did not go busy");

  // A stalled result holds its valid and payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(left_out_o)
      && $stable(right_out_o) && $stable(last_o))
    else $error("stalled result changed");

  // A result that is not the last of its frame is followed at once by the next.
  a_frame_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("gap inside a frame's results");

endmodule

bind stereo_linear_resampler srl_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_srl_checker (.*);

// File: test/tb_top.sv
// Self-checking testbench for stereo_linear_resampler: a directed table of frames
// followed by random phases, each result checked against a built-in predictor or a typed-in value.
// Depends on srl_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb_top;
  import srl_pkg::*;

  localparam logic [19:0] ONE_PHASE      = 20'h10000;
  localparam logic [31:0] PITCH_LO       = 32'd4096;
  localparam logic [31:0] PITCH_HI       = 32'd524288;
  localparam int          SETTLE_CYCLES  = 16;
  localparam int          LIMIT_CYCLES   = 400000;
  localparam int          DIR_ROWS       = 25;
  localparam int          RAND_PHASES    = 6;
  localparam int          PHASE_FRAMES   = 16;
  localparam int          MAX_REPORTS    = 10;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_RUNS, STALL_HEAVY} stall_mode_e;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        last_flag;
  } out_frame_t;

  // One register setting for a whole phase; set 0 of the directed part keeps
  // the values left by reset.
  typedef struct packed {
    logic [31:0] pitch;
    logic [31:0] loop_w;
    logic [31:0] dur;
  } reg_set_t;

  // A directed frame. Where known is set, the single result is typed in.
  typedef struct packed {
    logic [2:0]  set_id;
    logic [15:0] l;
    logic [15:0] r;
    logic        known;
    logic [15:0] el;
    logic [15:0] er;
  } dir_row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = CFG_PITCH_STEP;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic signed [15:0]    left_in_i   = '0;
  logic signed [15:0]    right_in_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [15:0]    left_out_o;
  logic signed [15:0]    right_out_o;
  logic                  last_o;

  stereo_linear_resampler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .left_in_i   (left_in_i),
    .right_in_i  (right_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o),
    .last_o      (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: a shadow of the registers and of the interpolator.
  logic [19:0]        pitch_q    = 20'h10000;
  logic               loop_on    = 1'b0;
  logic [31:0]        wrap_len   = 32'hFFFF_FFFF;
  logic signed [15:0] last_l     = '0;
  logic signed [15:0] last_r     = '0;
  logic [19:0]        read_phase = '0;
  logic [31:0]        src_cursor = '0;

  out_frame_t  expected_out_q[$];
  int          err_cnt    = 0;
  int          cycle_cnt  = 0;
  int          burst_left = 0;
  int          gap_max    = 0;
  int          burst_max  = 1;
  stall_mode_e stall_mode = STALL_NONE;
  logic        stall_hold = 1'b0;
  int          stall_run  = 0;

  reg_set_t dir_sets [7];
  dir_row_t dir_rows [DIR_ROWS];

  // prev + phase * (new - prev), the product divided by one phase unit and
  // truncated toward zero.
  function automatic logic [15:0] lerp16(input logic signed [15:0] a,
                                         input logic signed [15:0] b,
                                         input logic [19:0] ph);
    longint span;
    longint prod;
    longint ph_l;
    span = b;
    span = span - a;
    ph_l = ph;
    prod = (ph_l * span) / 65536;
    prod = prod + a;
    return prod[15:0];
  endfunction

  // Mirror of a register write, including the pitch saturation.
  task automatic shadow_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    case (idx)
      CFG_PITCH_STEP: begin
        if (data < PITCH_LO) pitch_q = PITCH_LO[19:0];
        else if (data > PITCH_HI) pitch_q = PITCH_HI[19:0];
        else pitch_q = data[19:0];
      end
      CFG_LOOP_ENABLE:     loop_on = data[0];
      CFG_DURATION_FRAMES: wrap_len = data;
      default: ;
    endcase
  endtask

  // Steps the interpolator by one source frame and, when asked, queues the
  // output frames it produces.
  task automatic resample_frame(input logic signed [15:0] nl, input logic signed [15:0] nr,
                                input bit record_it);
    int          n;
    logic [19:0] nxt;
    out_frame_t  f;
    n = 0;
    while (read_phase < ONE_PHASE && n < int'(MAX_RESULTS)) begin
      nxt = read_phase + pitch_q;
      f.left      = lerp16(last_l, nl, read_phase);
      f.right     = lerp16(last_r, nr, read_phase);
      f.last_flag = (nxt >= ONE_PHASE) || (n == int'(MAX_RESULTS) - 1);
      if (record_it) expected_out_q.push_back(f);
      read_phase = nxt;
      n++;
    end
    if (read_phase >= ONE_PHASE) read_phase = read_phase - ONE_PHASE;
    src_cursor = src_cursor + 32'd1;
    // The wrap is checked once per source frame, after the cursor moves.
    if (loop_on && src_cursor >= wrap_len) begin
      src_cursor = '0;
      read_phase = '0;
    end
    last_l = nl;
    last_r = nr;
  endtask

  // Writes all three registers on consecutive edges. Only called while idle.
  task automatic apply_settings(input reg_set_t s);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PITCH_STEP;
    cfg_data_i <= s.pitch;
    @(posedge clk_i);
    shadow_write(CFG_PITCH_STEP, s.pitch);
    cfg_idx_i  <= CFG_LOOP_ENABLE;
    cfg_data_i <= s.loop_w;
    @(posedge clk_i);
    shadow_write(CFG_LOOP_ENABLE, s.loop_w);
    cfg_idx_i  <= CFG_DURATION_FRAMES;
    cfg_data_i <= s.dur;
    @(posedge clk_i);
    shadow_write(CFG_DURATION_FRAMES, s.dur);
    cfg_we_i   <= 1'b0;
  endtask

  // Offers one frame request and returns at the edge that accepts it. The
  // sender runs in bursts; between bursts the payload carries junk with
  // valid low.
  task automatic push_frame(input logic [15:0] l, input logic [15:0] r);
    int          gap;
    logic [31:0] junk;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        junk = $urandom;
        in_valid_i <= 1'b0;
        left_in_i  <= junk[15:0];
        right_in_i <= junk[31:16];
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, burst_max);
    end
    in_valid_i <= 1'b1;
    left_in_i  <= l;
    right_in_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
  endtask

  // Drops valid, waits for every queued result, then lets the pipeline
  // flush frames that produce nothing before the registers change.
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_out_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_sample();
    logic [31:0] x;
    x = $urandom;
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return x[15:0];
    endcase
  endfunction

  function automatic reg_set_t rand_settings();
    reg_set_t s;
    case ($urandom_range(0, 5))
      0:       s.pitch = $urandom;
      1:       s.pitch = $urandom_range(0, PITCH_LO - 1);
      2:       s.pitch = $urandom_range(PITCH_LO, 32'h10000);
      3:       s.pitch = $urandom_range(32'h10000, 32'h20000);
      default: s.pitch = $urandom_range(PITCH_LO, PITCH_HI + 32'd64);
    endcase
    s.loop_w = $urandom;
    s.dur    = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 24);
    return s;
  endfunction

  task automatic report_mismatch(input out_frame_t want);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $display("mismatch at %0t: left %0d exp %0d, right %0d exp %0d, last %0b exp %0b",
               $realtime, left_out_o, $signed(want.left), right_out_o,
               $signed(want.right), last_o, want.last_flag);
  endtask

  // Output side: check every accepted result against the oldest expectation
  // and choose the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_out_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("unexpected result at %0t: left %0d right %0d last %0b",
                     $realtime, left_out_o, right_out_o, last_o);
        end else if (left_out_o !== expected_out_q[0].left ||
                     right_out_o !== expected_out_q[0].right ||
                     last_o !== expected_out_q[0].last_flag) begin
          report_mismatch(expected_out_q.pop_front());
        end else begin
          void'(expected_out_q.pop_front());
        end
      end
      case (stall_mode)
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        STALL_RUNS: begin
          if (stall_run == 0) begin
            stall_hold = !stall_hold;
            stall_run  = $urandom_range(1, 20);
          end
          stall_run--;
          out_stall_i <= stall_hold;
        end
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [2:0]  cur_set;
    logic [15:0] sl;
    logic [15:0] sr;

    // Directed settings: pitch below the minimum, above the maximum, both
    // exact limits, a loop bit hidden among set bits, and durations of zero,
    // one, a few frames and the largest value.
    dir_sets[0] = '{pitch: 32'h0001_0000, loop_w: 32'h0, dur: 32'hFFFF_FFFF};
    dir_sets[1] = '{pitch: 32'h0000_0000, loop_w: 32'h0, dur: 32'hFFFF_FFFF};
    dir_sets[2] = '{pitch: 32'hFFFF_FFFF, loop_w: 32'hFFFF_FFFE, dur: 32'h0};
    dir_sets[3] = '{pitch: 32'h0001_8000, loop_w: 32'h1, dur: 32'h0};
    dir_sets[4] = '{pitch: 32'h0000_C000, loop_w: 32'h1, dur: 32'd3};
    dir_sets[5] = '{pitch: PITCH_HI, loop_w: 32'h1, dur: 32'd1};
    dir_sets[6] = '{pitch: PITCH_LO, loop_w: 32'h0, dur: 32'h7FFF_FFFF};

    // Right after reset the pitch is one and the phase zero, so each frame
    // gives exactly one result equal to the frame before it, starting from
    // the cleared previous frame.
    dir_rows = '{
      '{0, 16'h7FFF, 16'h8000, 1'b1, 16'h0000, 16'h0000},
      '{0, 16'h8000, 16'h7FFF, 1'b1, 16'h7FFF, 16'h8000},
      '{0, 16'hFFFF, 16'h0000, 1'b1, 16'h8000, 16'h7FFF},
      '{0, 16'h0000, 16'hFFFF, 1'b1, 16'hFFFF, 16'h0000},
      '{0, 16'h5555, 16'hAAAA, 1'b1, 16'h0000, 16'hFFFF},
      '{0, 16'hAAAA, 16'h5555, 1'b1, 16'h5555, 16'hAAAA},
      '{1, 16'h8000, 16'h7FFF, 1'b0, 16'h0, 16'h0},
      '{1, 16'h7FFF, 16'h8000, 1'b0, 16'h0, 16'h0},
      '{2, 16'h0064, 16'hFF9C, 1'b0, 16'h0, 16'h0},
      '{2, 16'h8000, 16'h8000, 1'b0, 16'h0, 16'h0},
      '{2, 16'h7FFF, 16'h7FFF, 1'b0, 16'h0, 16'h0},
      '{2, 16'h0000, 16'h0000, 1'b0, 16'h0, 16'h0},
      '{3, 16'h1234, 16'hEDCC, 1'b0, 16'h0, 16'h0},
      '{3, 16'h8000, 16'h7FFF, 1'b0, 16'h0, 16'h0},
      '{3, 16'h7FFF, 16'h8000, 1'b0, 16'h0, 16'h0},
      '{4, 16'h0100, 16'hFF00, 1'b0, 16'h0, 16'h0},
      '{4, 16'h8000, 16'h7FFF, 1'b0, 16'h0, 16'h0},
      '{4, 16'h7FFF, 16'h8000, 1'b0, 16'h0, 16'h0},
      '{4, 16'h0001, 16'hFFFF, 1'b0, 16'h0, 16'h0},
      '{4, 16'hC000, 16'h4000, 1'b0, 16'h0, 16'h0},
      '{4, 16'h3FFF, 16'hC001, 1'b0, 16'h0, 16'h0},
      '{5, 16'h7FFF, 16'h8000, 1'b0, 16'h0, 16'h0},
      '{5, 16'h8000, 16'h7FFF, 1'b0, 16'h0, 16'h0},
      '{6, 16'h8000, 16'h7FFF, 1'b0, 16'h0, 16'h0},
      '{6, 16'h7FFF, 16'h8000, 1'b0, 16'h0, 16'h0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with mild idling on both sides.
    gap_max    = 3;
    burst_max  = 5;
    stall_mode = STALL_LIGHT;
    cur_set    = 3'd0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_id != cur_set) begin
        drain_and_settle();
        cur_set = dir_rows[i].set_id;
        apply_settings(dir_sets[cur_set]);
      end
      push_frame(dir_rows[i].l, dir_rows[i].r);
      if (dir_rows[i].known) begin
        expected_out_q.push_back('{left: dir_rows[i].el, right: dir_rows[i].er,
                                   last_flag: 1'b1});
        resample_frame(dir_rows[i].l, dir_rows[i].r, 1'b0);
      end else begin
        resample_frame(dir_rows[i].l, dir_rows[i].r, 1'b1);
      end
    end

    // Random phases, each with fresh settings and its own idling pattern.
    // The first one runs with no idling at all.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_and_settle();
      if (ph == 0) begin
        gap_max    = 0;
        burst_max  = 1;
        stall_mode = STALL_NONE;
      end else begin
        gap_max    = $urandom_range(0, 15);
        burst_max  = $urandom_range(1, 12);
        stall_mode = stall_mode_e'($urandom_range(0, 3));
      end
      apply_settings(rand_settings());
      repeat (PHASE_FRAMES) begin
        sl = rand_sample();
        sr = rand_sample();
        push_frame(sl, sr);
        resample_frame(sl, sr, 1'b1);
      end
    end

    drain_and_settle();
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
